[hdl/gbcc_pkg.sv]
package gbcc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STAMP_W    = 64;
    localparam int GYRO_AXES  = 3;
    localparam int ACCEL_AXES = 3;
    localparam int TDATA_W    = (GYRO_AXES + ACCEL_AXES) * SAMPLE_W + STAMP_W;
    localparam int STAMP_LSB  = (GYRO_AXES + ACCEL_AXES) * SAMPLE_W;

    typedef enum logic [2:0] {
        ST_CAL,
        ST_LOAD,
        ST_DIV,
        ST_FIN,
        ST_RUN
    } state_t;

endpackage

[hdl/gyro_bias_calibrate_correct_core.sv]
// A measurement request is accepted and its result is held in the output register
// from the next cycle on. Throughput: one request per cycle while the result side is ready.
// After the last calibration request the input stalls while the biases are formed: ST_LOAD
// takes the magnitudes, ST_DIV does a reciprocal multiplication and ST_FIN applies the sign.
// Reset (aresetn low, synchronous) clears the sums, the sample count and the last timestamp
// and restarts calibration.
module gyro_bias_calibrate_correct_core #(
    parameter int CAL_SAMPLES = 300,
    parameter int AXES        = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, stamp_ns
    input  logic [gbcc_pkg::TDATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // corr_gyro_x, corr_gyro_y, corr_gyro_z, out_accel_x, out_accel_y, out_accel_z, elapsed_ns
    output logic [gbcc_pkg::TDATA_W-1:0]  m_tdata
);
    import gbcc_pkg::*;

    localparam int CW = $clog2(CAL_SAMPLES + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam int MW = SW - 1;
    localparam int RL = $clog2(CAL_SAMPLES);
    localparam int SH = MW + RL;
    localparam int PW = 2 * MW + 1;
    localparam logic [MW:0] RECIP =
        (MW + 1)'(((64'd1 << SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    state_t state_reg, state_next;

    logic [CW-1:0]            cal_count_reg;
    logic signed [SW-1:0]     sum_reg [AXES];
    logic [MW-1:0]            quo_reg [AXES];
    logic                     neg_reg [AXES];
    logic [SAMPLE_W-1:0]      bias_reg [AXES];
    logic [STAMP_W-1:0]       last_stamp_reg;
    logic                     m_tvalid_reg;
    logic [TDATA_W-1:0]       m_tdata_reg;

    logic                     s_accept;
    logic                     last_cal;
    logic [SW-1:0]            sum_next [AXES];
    logic [SW-1:0]            sum_neg [AXES];
    logic [MW-1:0]            mag [AXES];
    logic [PW-1:0]            prod [AXES];
    logic [SAMPLE_W-1:0]      corr [GYRO_AXES];
    logic [TDATA_W-1:0]       result_data;

    assign s_tready = (state_reg == ST_CAL) ||
                      ((state_reg == ST_RUN) && (!m_tvalid_reg || m_tready));
    assign s_accept = s_tvalid && s_tready;
    assign last_cal = (cal_count_reg == CW'(CAL_SAMPLES - 1));

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            sum_next[a]  = sum_reg[a] + {{(SW - SAMPLE_W){s_tdata[a*SAMPLE_W + SAMPLE_W - 1]}},
                                         s_tdata[a*SAMPLE_W +: SAMPLE_W]};
            sum_neg[a]   = -sum_reg[a];
            mag[a]       = sum_reg[a][SW-1] ? sum_neg[a][MW-1:0] : sum_reg[a][MW-1:0];
            prod[a]      = PW'(quo_reg[a]) * PW'(RECIP);
        end
    end

    for (genvar g = 0; g < GYRO_AXES; g++) begin : g_axis
        logic [SAMPLE_W-1:0] raw;
        assign raw = s_tdata[g*SAMPLE_W +: SAMPLE_W];
        if (g < AXES) begin : g_corr
            logic [SAMPLE_W:0] diff;
            assign diff = {raw[SAMPLE_W-1], raw} - {bias_reg[g][SAMPLE_W-1], bias_reg[g]};
            always_comb begin
                if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
                    corr[g] = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                             : {1'b0, {(SAMPLE_W - 1){1'b1}}};
                end else begin
                    corr[g] = diff[SAMPLE_W-1:0];
                end
            end
        end else begin : g_raw
            assign corr[g] = raw;
        end
        assign result_data[g*SAMPLE_W +: SAMPLE_W] = corr[g];
    end

    assign result_data[STAMP_LSB-1:GYRO_AXES*SAMPLE_W] = s_tdata[STAMP_LSB-1:GYRO_AXES*SAMPLE_W];
    assign result_data[TDATA_W-1:STAMP_LSB] = s_tdata[TDATA_W-1:STAMP_LSB] - last_stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CAL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CAL: begin
                if (s_accept && last_cal) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CAL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg  <= '0;
            last_stamp_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            if (state_reg == ST_CAL && s_accept) begin
                cal_count_reg <= cal_count_reg + CW'(1);
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= sum_next[a];
                end
            end
            if (state_reg == ST_RUN && s_accept) begin
                last_stamp_reg <= s_tdata[TDATA_W-1:STAMP_LSB];
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < AXES; a++) begin
            if (state_reg == ST_LOAD) begin
                quo_reg[a] <= mag[a];
                neg_reg[a] <= sum_reg[a][SW-1];
            end else if (state_reg == ST_DIV) begin
                quo_reg[a] <= MW'(prod[a][SH +: SAMPLE_W]);
            end
            if (state_reg == ST_FIN) begin
                bias_reg[a] <= neg_reg[a] ? -quo_reg[a][SAMPLE_W-1:0] : quo_reg[a][SAMPLE_W-1:0];
            end
        end
        if (state_reg == ST_RUN && s_accept) begin
            m_tdata_reg <= result_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
